// ----- hw/rtl/cpmr_pkg.sv -----
// Shared types and constants for the CAN parameter mailbox rotator.
// Used by every module under hw/rtl; depends on nothing else.
package cpmr_pkg;

    localparam int unsigned STORE_DEPTH = 13;
    localparam int unsigned WORDS_PER_FRAME = 3;

    localparam logic [28:0] BASE_ID   = 29'h000BB20;
    localparam logic [28:0] CHANGE_ID = 29'h000BB30;
    localparam logic [28:0] CHANGE_ID_LAST = CHANGE_ID + 29'd4;
    localparam logic [7:0]  STATUS_MAGIC = 8'h67;
    localparam logic [7:0]  SET_TAG = 8'h78;
    localparam logic [15:0] DUTY_MAX = 16'd100;
    localparam logic [15:0] OFF_DEFAULT = 16'd1000;
    localparam logic [3:0]  MIN_LENGTH = 4'd7;

    localparam int unsigned BUILD_YEAR  = 2025;
    localparam int unsigned BUILD_MONTH = 2;
    localparam int unsigned BUILD_DAY   = 13;
    localparam logic [7:0] VER_CENTURY = 8'(BUILD_YEAR / 100);
    localparam logic [7:0] VER_YEAR    = 8'(BUILD_YEAR % 100);
    localparam logic [7:0] VER_MONTH   = 8'(BUILD_MONTH);
    localparam logic [7:0] VER_DAY     = 8'(BUILD_DAY);

    localparam logic [63:0] STATUS_PAYLOAD = {STATUS_MAGIC, 56'h0};
    localparam logic [63:0] VERSION_PAYLOAD =
        {24'h0, VER_DAY, VER_MONTH, VER_YEAR, VER_CENTURY, 8'h00};

    // Result kinds.
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_BOOST = 2'd1;
    localparam logic [1:0] KIND_INJ   = 2'd2;

    // Rotation slots.
    localparam logic [2:0] ROT_CFG1    = 3'd0;
    localparam logic [2:0] ROT_CFG2    = 3'd1;
    localparam logic [2:0] ROT_CFG3    = 3'd2;
    localparam logic [2:0] ROT_CFG4    = 3'd3;
    localparam logic [2:0] ROT_VERSION = 3'd4;
    localparam logic [2:0] ROT_STATUS  = 3'd5;

    // Frame numbers that produce a result.
    localparam logic [2:0] FRAME_BOOST = 3'd0;
    localparam logic [2:0] FRAME_INJ   = 3'd2;

    typedef struct packed {
        logic        command;
        logic        rx_extended;
        logic [3:0]  rx_length;
        logic [28:0] rx_id;
        logic [63:0] rx_payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [28:0] tx_id;
        logic [63:0] tx_payload;
        logic [6:0]  boost_duty;
        logic [15:0] inj_on_time;
        logic [15:0] inj_off_time;
        logic        last;
    } result_t;

endpackage

// ----- hw/rtl/cpmr_in_stage.sv -----
// Input register of the mailbox rotator: holds one accepted item.
// Depends on cpmr_pkg for the item type.
module cpmr_in_stage
    import cpmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register frees up in the same cycle that its item moves on.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/cpmr_engine.sv -----
// Parameter store, rotation counter and result formation of the mailbox rotator.
// Depends on cpmr_pkg for constants and the item and result types.
module cpmr_engine
    import cpmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       commit,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_count
);

    logic [15:0] store_reg [STORE_DEPTH];
    logic [2:0]  rot_reg;
    logic [2:0]  rot_next;

    logic        frame_ok;
    logic [2:0]  frame_num;
    logic [28:0] id_offset;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [28:0] cfg_id;
    logic [63:0] cfg_payload;
    result_t     status_res;

    assign id_offset = item.rx_id - CHANGE_ID;
    assign frame_num = id_offset[2:0];
    assign word0     = item.rx_payload[23:8];
    assign word1     = item.rx_payload[39:24];

    assign frame_ok = !item.command && item.rx_extended && (item.rx_length >= MIN_LENGTH)
                      && (item.rx_id >= CHANGE_ID) && (item.rx_id <= CHANGE_ID_LAST)
                      && (item.rx_payload[7:0] == SET_TAG);

    assign rot_next = (rot_reg >= ROT_STATUS) ? ROT_CFG1 : rot_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= ROT_CFG1;
        end
        else if (commit && item.command)
        begin
            rot_reg <= rot_next;
        end
    end

    // Each entry takes one fixed word of one fixed frame.
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_store
        localparam logic [2:0] EntryFrame = 3'(i / WORDS_PER_FRAME);
        localparam int unsigned EntryWord = i % WORDS_PER_FRAME;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                store_reg[i] <= 16'h0;
            end
            else if (commit && frame_ok && (frame_num == EntryFrame))
            begin
                store_reg[i] <= item.rx_payload[8 + 16 * EntryWord +: 16];
            end
        end
    end

    always_comb
    begin
        case (rot_next)
            ROT_CFG1:
            begin
                cfg_id      = BASE_ID + 29'd1;
                cfg_payload = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
            end
            ROT_CFG2:
            begin
                cfg_id      = BASE_ID + 29'd2;
                cfg_payload = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
            end
            ROT_CFG3:
            begin
                cfg_id      = BASE_ID + 29'd3;
                cfg_payload = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
            end
            ROT_CFG4:
            begin
                cfg_id      = BASE_ID + 29'd4;
                cfg_payload = {48'h0, store_reg[12]};
            end
            ROT_VERSION:
            begin
                cfg_id      = BASE_ID + 29'd5;
                cfg_payload = VERSION_PAYLOAD;
            end
            default:
            begin
                cfg_id      = BASE_ID;
                cfg_payload = STATUS_PAYLOAD;
            end
        endcase
    end

    always_comb
    begin
        status_res            = '0;
        status_res.result_kind = KIND_TX;
        status_res.tx_id      = BASE_ID;
        status_res.tx_payload = STATUS_PAYLOAD;

        res0      = '0;
        res1      = '0;
        res_count = 2'd0;

        if (item.command)
        begin
            res0            = status_res;
            res1            = status_res;
            res1.tx_id      = cfg_id;
            res1.tx_payload = cfg_payload;
            res1.last       = 1'b1;
            res_count       = 2'd2;
        end
        else if (frame_ok && (frame_num == FRAME_BOOST))
        begin
            // The duty comes from the word being stored right now.
            res0.result_kind = KIND_BOOST;
            res0.boost_duty  = (word0 > DUTY_MAX) ? DUTY_MAX[6:0] : word0[6:0];
            res0.last        = 1'b1;
            res_count        = 2'd1;
        end
        else if (frame_ok && (frame_num == FRAME_INJ))
        begin
            // Bypass (entry 7) is the middle word of this very frame.
            res0.result_kind  = KIND_INJ;
            res0.inj_on_time  = store_reg[5];
            res0.inj_off_time = (word1 != 16'h0) ? word1 : OFF_DEFAULT;
            res0.last         = 1'b1;
            res_count         = 2'd1;
        end
    end

endmodule

// ----- hw/rtl/cpmr_out_buf.sv -----
// Two-entry result buffer of the mailbox rotator, drained in order.
// Depends on cpmr_pkg for the result type.
module cpmr_out_buf
    import cpmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_take,
    input  result_t    res0,
    input  result_t    res1,
    input  logic [1:0] res_count,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && out_ready;
    // A new item may load once the buffer is empty or empties this cycle.
    assign item_take = item_valid
                       && ((count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready));

    always_comb
    begin
        if (item_take)
        begin
            count_next = res_count;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot0_reg;

endmodule

// ----- hw/rtl/can_parameter_mailbox_rotator_core.sv -----
// Top level of the CAN parameter mailbox rotator.
// Depends on cpmr_pkg, cpmr_in_stage, cpmr_engine and cpmr_out_buf.
//
//   Channel   Direction  Contents (tdata / tuser / tlast)
//   s_axis    in         received frame fields / command / -
//   m_axis    out        frame, duty and injector fields / result kind / last
//
// An accepted item is held in the input register; in the cycle it leaves, the
// engine stores its words and loads all of its results into the two-entry
// output buffer at once. A transmit tick gives two results and a received
// frame at most one, and the output port drains the buffer at one result per
// cycle while m_axis_tready is high. A new item enters while the last result
// of the previous one is being taken. Stalls on m_axis back up into s_axis
// without loss. Reset clears the parameter store, the rotation count and all
// valid flags.
module can_parameter_mailbox_rotator_core
    import cpmr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Bits from 0: rx_extended(1), rx_length(4), rx_id(29), rx_payload(64), zeros(6).
    input  logic [103:0] s_axis_tdata,
    // Bits from 0: command(1).
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Bits from 0: tx_id(29), tx_payload(64), boost_duty(7), inj_on_time(16),
    // inj_off_time(16), zeros(4).
    output logic [135:0] m_axis_tdata,
    // Bits from 0: result_kind(2).
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    logic       item_take;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_count;
    result_t    out_res;

    // Unpack the incoming transfer into the item fields.
    always_comb
    begin
        in_item.command     = s_axis_tuser;
        in_item.rx_extended = s_axis_tdata[0];
        in_item.rx_length   = s_axis_tdata[4:1];
        in_item.rx_id       = s_axis_tdata[33:5];
        in_item.rx_payload  = s_axis_tdata[97:34];
    end

    cpmr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // The engine commits store and rotation updates only when the item leaves
    // the input register, so every item sees the effect of all earlier ones.
    cpmr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .commit    (item_take),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    cpmr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    // Pack the result into the outgoing transfer.
    assign m_axis_tdata = {4'h0, out_res.inj_off_time, out_res.inj_on_time,
                           out_res.boost_duty, out_res.tx_payload, out_res.tx_id};
    assign m_axis_tuser = out_res.result_kind;
    assign m_axis_tlast = out_res.last;

endmodule
